### hdl/qia_pkg.sv
// Shared types, sizes and word layouts for the quick-init array.
package qia_pkg;

    // Array geometry
    localparam int CELLS   = 1024;
    localparam int WRITERS = 4;

    localparam int IDX_W   = 10;          // cell index width
    localparam int WR_W    = 2;           // writer id width
    localparam int VAL_W   = 32;          // cell value width
    localparam int FILL_W  = IDX_W + 1;   // fill count holds 0..CELLS
    localparam int LIST_AW = WR_W + IDX_W; // certificate list address

    // Input word layout, lowest bit first
    localparam int IN_ACT_LSB = 0;
    localparam int IN_WR_LSB  = IN_ACT_LSB + 1;
    localparam int IN_IDX_LSB = IN_WR_LSB + WR_W;
    localparam int IN_VAL_LSB = IN_IDX_LSB + IDX_W;
    localparam int IN_BITS    = IN_VAL_LSB + VAL_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef logic [IDX_W-1:0]  t_cell_idx;
    typedef logic [WR_W-1:0]   t_writer;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [FILL_W-1:0] t_fill;

    // Certificate pointer: owning writer and slot in its list
    typedef struct packed {
        t_writer   writer;
        t_cell_idx slot;
    } t_cert_ptr;

endpackage

### hdl/quick_init_array_top.sv
// Quick-init array top level: cell store, certificate store and access sequencer.
//
// Array of 1024 signed 32-bit cells that read as a programmable default until
// written, without any clearing pass after reset.
// Input stream (s_axis): one word per access; read or write a cell, with the
// writer id and value used on writes. Output stream (m_axis): one word per
// read carrying the cell value; writes produce no output word.
// Config port: i_cfg_wr_en / i_cfg_wr_data load the default value.
// An accepted read passes the pointer and check states before its word is
// registered onto m_axis. The sequencer finishes one access before taking
// the next; it walks a chain of dependent memory reads: certificate pointer
// and cell value, then the writer's list slot and fill count, then the check
// and any writes. s_axis_tready is high only while the sequencer is idle.
// Reset clears only the sequencer, the output valid flag, the default value
// and the four fill counts; the memories keep whatever they hold and are
// validated through the certificates.
// A stalled m_axis receiver holds the result in the output register; the
// next access is still accepted, and a following read waits in its check
// step until the register frees up.
module quick_init_array_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // fields from bit 0: action, writer[1:0], cell_index[9:0], write_value[31:0]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [qia_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // fields from bit 0: read_value[31:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [qia_pkg::VAL_W-1:0]     o_m_axis_tdata,
    // default value register
    input  logic                          i_cfg_wr_en,
    input  logic [qia_pkg::VAL_W-1:0]     i_cfg_wr_data
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PTR  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;

    localparam qia_pkg::t_fill CELLS_FILL = qia_pkg::FILL_W'(qia_pkg::CELLS);

    // Memories (no reset)
    qia_pkg::t_value    mem_val  [qia_pkg::CELLS];
    qia_pkg::t_cert_ptr mem_ptr  [qia_pkg::CELLS];
    qia_pkg::t_cell_idx mem_list [qia_pkg::WRITERS * qia_pkg::CELLS];

    // Control and payload registers
    logic [1:0]          r_state, n_state;
    qia_pkg::t_fill      r_fill [qia_pkg::WRITERS];
    qia_pkg::t_value     r_default;
    logic                r_out_valid;
    qia_pkg::t_value     r_out_data;

    logic                r_act;
    qia_pkg::t_writer    r_wr;
    qia_pkg::t_cell_idx  r_idx;
    qia_pkg::t_value     r_wval;
    qia_pkg::t_value     r_cell_q;
    qia_pkg::t_cert_ptr  r_ptr_q;
    qia_pkg::t_cell_idx  r_list_q;
    logic                r_in_fill;

    logic                in_acc;
    logic                out_acc;
    logic                cert_ok;
    logic                do_write;
    logic                do_register;
    logic                read_done;
    qia_pkg::t_fill      wr_fill;
    logic [qia_pkg::FILL_W+1:0] fill_sum;

    // Input field unpack
    logic                in_act;
    qia_pkg::t_writer    in_wr;
    qia_pkg::t_cell_idx  in_idx;
    qia_pkg::t_value     in_val;

    assign in_act = i_s_axis_tdata[qia_pkg::IN_ACT_LSB];
    assign in_wr  = i_s_axis_tdata[qia_pkg::IN_WR_LSB +: qia_pkg::WR_W];
    assign in_idx = i_s_axis_tdata[qia_pkg::IN_IDX_LSB +: qia_pkg::IDX_W];
    assign in_val = i_s_axis_tdata[qia_pkg::IN_VAL_LSB +: qia_pkg::VAL_W];

    // Handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign out_acc         = r_out_valid && i_m_axis_tready;

    // Check step decisions
    assign cert_ok     = r_in_fill && (r_list_q == r_idx);
    assign wr_fill     = r_fill[r_wr];
    assign do_write    = (r_state == S_CHK) && (r_act == qia_pkg::ACT_WRITE);
    assign do_register = do_write && !cert_ok && (wr_fill < CELLS_FILL);
    assign read_done   = (r_state == S_CHK) && (r_act == qia_pkg::ACT_READ)
                         && (!r_out_valid || i_m_axis_tready);

    // Total fill, for checks
    always_comb begin
        fill_sum = '0;
        for (int k = 0; k < qia_pkg::WRITERS; k++) begin
            fill_sum = fill_sum + (qia_pkg::FILL_W + 2)'(r_fill[k]);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_PTR;
            S_PTR:  n_state = S_CHK;
            S_CHK:  if (do_write || read_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_default   <= '0;
            for (int k = 0; k < qia_pkg::WRITERS; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_default <= i_cfg_wr_data;
            if (read_done) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (do_register) r_fill[r_wr] <= wr_fill + 1'b1;
        end
    end

    // Access payload and result data
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act  <= in_act;
            r_wr   <= in_wr;
            r_idx  <= in_idx;
            r_wval <= in_val;
        end
        // slot check; unknown contents resolve to "not certified"
        if (r_state == S_PTR) begin
            if (qia_pkg::FILL_W'(r_ptr_q.slot) < r_fill[r_ptr_q.writer]) begin
                r_in_fill <= 1'b1;
            end else begin
                r_in_fill <= 1'b0;
            end
        end
        if (read_done) begin
            if (cert_ok) begin
                r_out_data <= r_cell_q;
            end else begin
                r_out_data <= r_default;
            end
        end
    end

    // Cell value and certificate pointer memories
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cell_q <= mem_val[in_idx];
            r_ptr_q  <= mem_ptr[in_idx];
        end
        if (do_write) mem_val[r_idx] <= r_wval;
        if (do_register) mem_ptr[r_idx] <= '{writer: r_wr, slot: wr_fill[qia_pkg::IDX_W-1:0]};
    end

    // Certificate list memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_PTR) r_list_q <= mem_list[r_ptr_q];
        if (do_register) mem_list[{r_wr, wr_fill[qia_pkg::IDX_W-1:0]}] <= r_idx;
    end

    // Checks
    a_acc_to_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PTR))
        else $error("accepted access did not start pointer lookup");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fill_sum == $past(fill_sum)) || (fill_sum == $past(fill_sum) + 1'b1))
        else $error("fill counts moved by more than one");

    a_fill_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_write |=> (fill_sum == $past(fill_sum)))
        else $error("fill count changed outside a write check");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_CHK)
            && ($past(r_act) == qia_pkg::ACT_READ))
        else $error("output word without a read check");

endmodule

### tb/quick_init_array_top_tb.sv
// Self-checking testbench for the quick-init array: directed table, then randomized phases.
module quick_init_array_top_tb;

    localparam int RUN_LIMIT   = 200000;   // cycles before the run is declared hung
    localparam int SETTLE      = 8;        // covers a write still in flight
    localparam int ROWS        = 20;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 150;

    // One access as the sender sees it
    typedef struct packed {
        logic               action;
        qia_pkg::t_writer   writer;
        qia_pkg::t_cell_idx target;
        qia_pkg::t_value    value;
    } t_cell_access;

    // Directed row: access plus an optional typed-in read result
    typedef struct packed {
        logic               action;
        qia_pkg::t_writer   writer;
        qia_pkg::t_cell_idx target;
        qia_pkg::t_value    value;
        logic               pinned;
        qia_pkg::t_value    want;
    } t_stim_row;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // fields from bit 0: action, writer[1:0], cell_index[9:0], write_value[31:0]
    logic [qia_pkg::IN_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // fields from bit 0: read_value[31:0]
    logic [qia_pkg::VAL_W-1:0]      o_m_axis_tdata;
    logic                           i_cfg_wr_en     = 1'b0;
    logic [qia_pkg::VAL_W-1:0]      i_cfg_wr_data   = '0;

    // Shadow of the array: values, certificates, per-writer lists and fill counts
    qia_pkg::t_value    cell_store [qia_pkg::CELLS];
    qia_pkg::t_cert_ptr cert_of    [qia_pkg::CELLS];
    qia_pkg::t_cell_idx cert_list  [qia_pkg::WRITERS][qia_pkg::CELLS];
    qia_pkg::t_fill     fill_of    [qia_pkg::WRITERS];
    qia_pkg::t_value    default_now = '0;

    qia_pkg::t_value pending_reads [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int reads_checked = 0;
    int default_reads = 0;
    int cycles        = 0;

    // Default settings per random phase; phase 3 draws its own at run time
    qia_pkg::t_value phase_default [PHASES] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                                32'h0000_0000, 32'h0000_0000};
    int     phase_send_idle  [PHASES] = '{0, 74, 0, 11, 0};
    int     phase_recv_stall [PHASES] = '{0, 0, 74, 11, 0};

    // Directed accesses: corner cells, extreme values, rewrites by same and other writer
    t_stim_row directed_rows [ROWS] = '{
        '{qia_pkg::ACT_READ,  2'd0, 10'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{qia_pkg::ACT_READ,  2'd3, 10'd1023, 32'hdead_beef, 1'b1, 32'h0000_0000},
        '{qia_pkg::ACT_WRITE, 2'd0, 10'd0,    32'h7fff_ffff, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd0, 10'd0,    32'h0000_0000, 1'b1, 32'h7fff_ffff},
        '{qia_pkg::ACT_WRITE, 2'd3, 10'd1023, 32'h8000_0000, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd0, 10'd1023, 32'h0000_0000, 1'b1, 32'h8000_0000},
        '{qia_pkg::ACT_WRITE, 2'd1, 10'd0,    32'hffff_ffff, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd2, 10'd0,    32'h0000_0000, 1'b1, 32'hffff_ffff},
        '{qia_pkg::ACT_WRITE, 2'd3, 10'd1,    32'h5555_5555, 1'b0, 32'h0},
        '{qia_pkg::ACT_WRITE, 2'd3, 10'd1,    32'haaaa_aaaa, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd0, 10'd1,    32'h0000_0000, 1'b1, 32'haaaa_aaaa},
        '{qia_pkg::ACT_WRITE, 2'd2, 10'd512,  32'h0000_0000, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd0, 10'd512,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{qia_pkg::ACT_READ,  2'd0, 10'd511,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{qia_pkg::ACT_WRITE, 2'd0, 10'd2,    32'h1234_5678, 1'b0, 32'h0},
        '{qia_pkg::ACT_WRITE, 2'd1, 10'd3,    32'h8765_4321, 1'b0, 32'h0},
        '{qia_pkg::ACT_WRITE, 2'd2, 10'd2,    32'h0000_0001, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd1, 10'd2,    32'hffff_ffff, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd0, 10'd3,    32'h0000_0000, 1'b0, 32'h0},
        '{qia_pkg::ACT_READ,  2'd2, 10'd1022, 32'h0000_0000, 1'b0, 32'h0}
    };

    quick_init_array_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A cell is live when its certificate names a filled slot that points back at it
    function automatic bit cert_holds(input qia_pkg::t_cell_idx c);
        qia_pkg::t_cert_ptr p;
        p = cert_of[c];
        return (qia_pkg::t_fill'(p.slot) < fill_of[p.writer])
               && (cert_list[p.writer][p.slot] == c);
    endfunction

    // Update the shadow for one access; returns 1 when the access yields a read word
    function automatic bit apply_access(input t_cell_access a, output qia_pkg::t_value rd);
        qia_pkg::t_fill n;
        rd = default_now;
        if (a.action == qia_pkg::ACT_READ) begin
            if (cert_holds(a.target))
                rd = cell_store[a.target];
            return 1'b1;
        end
        cell_store[a.target] = a.value;
        if (!cert_holds(a.target)) begin
            n = fill_of[a.writer];
            if (n < qia_pkg::t_fill'(qia_pkg::CELLS)) begin
                cert_list[a.writer][n[qia_pkg::IDX_W-1:0]] = a.target;
                fill_of[a.writer] = n + 1'b1;
                cert_of[a.target] = {a.writer, n[qia_pkg::IDX_W-1:0]};
            end
        end
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string what, input qia_pkg::t_value got,
                                 input qia_pkg::t_value want);
        $display("mismatch @%0d: %s got %h want %h", cycles, what, got, want);
        mismatches++;
    endtask

    // Drive one word, wait for the handshake, then queue the expected value if it is a read
    task automatic send_access(input t_cell_access a, input bit pinned,
                               input qia_pkg::t_value want);
        qia_pkg::t_value                rd;
        bit                             live;
        logic [qia_pkg::IN_TDATA_W-1:0] word;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        word = '0;
        word[qia_pkg::IN_ACT_LSB]                   = a.action;
        word[qia_pkg::IN_WR_LSB +: qia_pkg::WR_W]   = a.writer;
        word[qia_pkg::IN_IDX_LSB +: qia_pkg::IDX_W] = a.target;
        word[qia_pkg::IN_VAL_LSB +: qia_pkg::VAL_W] = a.value;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        live = cert_holds(a.target);
        if (apply_access(a, rd)) begin
            pending_reads.push_back(pinned ? want : rd);
            if (!live)
                default_reads++;
        end
    endtask

    // Hold the sender off until every read word is back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_reads.size() != 0);
    endtask

    // Load the default value with the block idle
    task automatic load_default(input qia_pkg::t_value v);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        default_now = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Output checker
    always @(posedge i_clk) begin : check_out
        qia_pkg::t_value want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                note_mismatch("read_value with no read pending", o_m_axis_tdata, '0);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (o_m_axis_tdata !== want)
                    note_mismatch("read_value", o_m_axis_tdata, want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycles,
                     pending_reads.size());
            $display("FAIL quick_init_array_top");
            $finish;
        end
    end

    initial begin : stimulus
        t_cell_access    a;
        int              r;
        qia_pkg::t_value setting;
        for (int c = 0; c < qia_pkg::CELLS; c++) begin
            cell_store[c] = '0;
            cert_of[c]    = '0;
        end
        for (int w = 0; w < qia_pkg::WRITERS; w++) begin
            fill_of[w] = '0;
            for (int c = 0; c < qia_pkg::CELLS; c++)
                cert_list[w][c] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset default
        for (int k = 0; k < ROWS; k++) begin
            a.action = directed_rows[k].action;
            a.writer = directed_rows[k].writer;
            a.target = directed_rows[k].target;
            a.value  = directed_rows[k].value;
            send_access(a, directed_rows[k].pinned, directed_rows[k].want);
        end

        // Random phases, each with its own default and idle/stall mix
        for (int p = 0; p < PHASES; p++) begin
            setting = (p == 3) ? qia_pkg::t_value'($urandom) : phase_default[p];
            load_default(setting);
            send_idle_pct = phase_send_idle[p];
            stall_pct     = phase_recv_stall[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == PHASE_ITEMS / 2)
                    drain_results();
                a.action = ($urandom_range(99) < 55) ? qia_pkg::ACT_READ : qia_pkg::ACT_WRITE;
                a.writer = qia_pkg::t_writer'($urandom_range(qia_pkg::WRITERS - 1));
                // hot low cells and the top eight cells get rewritten often, the rest stay mostly cold
                r = $urandom_range(99);
                if (r < 45)
                    a.target = qia_pkg::t_cell_idx'($urandom_range(31));
                else if (r < 60)
                    a.target = qia_pkg::t_cell_idx'(qia_pkg::CELLS - 1 - $urandom_range(7));
                else
                    a.target = qia_pkg::t_cell_idx'($urandom_range(qia_pkg::CELLS - 1));
                if ($urandom_range(9) == 0)
                    a.value = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
                else
                    a.value = qia_pkg::t_value'($urandom);
                send_access(a, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d directed + %0d random accesses, %0d reads checked, %0d %s",
                 ROWS, PHASES * PHASE_ITEMS, reads_checked, default_reads,
                 "on unwritten cells");
        $display("default value swept over both signed extremes, -1, zero and a random word");
        if (mismatches == 0 && pending_reads.size() == 0)
            $display("PASS quick_init_array_top");
        else
            $display("FAIL quick_init_array_top");
        $finish;
    end

endmodule

### sim.f
hdl/qia_pkg.sv
hdl/quick_init_array_top.sv
tb/quick_init_array_top_tb.sv
